// File: hdl/static_linked_list_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// static linked list engine assertion macros
// shared property forms, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define STATIC_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define SLLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/slle_pkg.sv
// ----------------------------------------------------------------------------
// slle_pkg
// codes, field widths and controller/datapath interface types
// ----------------------------------------------------------------------------
package slle_pkg;

    localparam int KIND_W = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // link read address source
    typedef enum logic [1:0] {
        RA_NEXT_CURSOR,
        RA_FREE_HEAD,
        RA_LINK_DATA
    } t_rd_sel;

    // link write address source
    typedef enum logic [2:0] {
        WA_CLEAR,
        WA_FREE_HEAD,
        WA_FRESH,
        WA_CURSOR,
        WA_NODE
    } t_wa_sel;

    // link write data source
    typedef enum logic [1:0] {
        WD_CLEAR,
        WD_LINK_DATA,
        WD_FRESH,
        WD_NODE
    } t_wd_sel;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_LOAD_HEAD,
        CUR_STEP
    } t_cur_op;

    typedef struct packed {
        logic              accept;
        logic              clr_step;
        t_rd_sel           rd_sel;
        logic              link_we;
        t_wa_sel           wa_sel;
        t_wd_sel           wd_sel;
        logic              byte_we;
        t_cur_op           cur_op;
        logic              steps_full;
        logic              cap_fresh;
        logic              cap_node;
        logic              cap_byte;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic              clr_last;
        logic [KIND_W-1:0] kind;
        logic              pos_ok_ins;
        logic              pos_ok_dr;
        logic              link_zero;
        logic              steps_zero;
        logic              out_free;
    } t_dp_stat;

endpackage

// File: hdl/slle_ram.sv
// ----------------------------------------------------------------------------
// slle_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module slle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/slle_datapath.sv
// ----------------------------------------------------------------------------
// slle_datapath
// link and byte stores, walk cursor, element count and result register
// ----------------------------------------------------------------------------
`include "static_linked_list_engine_unit_macros.svh"

module slle_datapath #(
    parameter int SLOTS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slle_pkg::t_dp_cmd             i_cmd,
    output slle_pkg::t_dp_stat            o_stat,
    input  logic [slle_pkg::KIND_W-1:0]   i_kind,
    input  logic [slle_pkg::POS_W-1:0]    i_position,
    input  logic [slle_pkg::VAL_W-1:0]    i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [slle_pkg::STAT_W-1:0]   o_status,
    output logic [slle_pkg::VAL_W-1:0]    o_read_value,
    output logic [slle_pkg::LEN_W-1:0]    o_list_length
);

    localparam int AW   = $clog2(SLOTS);
    localparam int CMPW = ((AW > slle_pkg::POS_W) ? AW : slle_pkg::POS_W) + 1;
    localparam logic [AW-1:0] DATA_HEAD = AW'(SLOTS - 1);
    localparam logic [AW-1:0] FREE_HEAD = '0;
    localparam logic [AW-1:0] LAST_FREE = AW'(SLOTS - 2);

    logic [slle_pkg::KIND_W-1:0] r_kind;
    logic [slle_pkg::POS_W-1:0]  r_pos;
    logic [slle_pkg::VAL_W-1:0]  r_val;
    logic [AW-1:0]               r_cursor, n_cursor;
    logic [slle_pkg::POS_W-1:0]  r_steps;
    logic [AW-1:0]               r_fresh;
    logic [AW-1:0]               r_node;
    logic [AW-1:0]               r_count;
    logic [AW-1:0]               r_clr;
    logic [slle_pkg::STAT_W-1:0] r_status;
    logic [slle_pkg::VAL_W-1:0]  r_rdval;
    logic                        r_out_valid;
    logic [slle_pkg::STAT_W-1:0] r_out_status;
    logic [slle_pkg::VAL_W-1:0]  r_out_rdval;
    logic [slle_pkg::LEN_W-1:0]  r_out_len;

    logic [AW-1:0]              link_rdata;
    logic [AW-1:0]              link_raddr;
    logic [AW-1:0]              link_waddr;
    logic [AW-1:0]              link_wdata;
    logic [slle_pkg::VAL_W-1:0] byte_rdata;
    logic [CMPW-1:0]            pos_ext;
    logic [CMPW-1:0]            cnt_ext;

    slle_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    slle_ram #(.WIDTH(slle_pkg::VAL_W), .DEPTH(SLOTS)) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.byte_we),
        .i_waddr (r_fresh),
        .i_wdata (r_val),
        .i_raddr (r_cursor),
        .o_rdata (byte_rdata)
    );

    always_comb begin
        case (i_cmd.cur_op)
            slle_pkg::CUR_LOAD_HEAD: n_cursor = DATA_HEAD;
            slle_pkg::CUR_STEP:      n_cursor = link_rdata;
            default:                 n_cursor = r_cursor;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            slle_pkg::RA_FREE_HEAD: link_raddr = FREE_HEAD;
            slle_pkg::RA_LINK_DATA: link_raddr = link_rdata;
            default:                link_raddr = n_cursor;
        endcase
    end

    always_comb begin
        case (i_cmd.wa_sel)
            slle_pkg::WA_FREE_HEAD: link_waddr = FREE_HEAD;
            slle_pkg::WA_FRESH:     link_waddr = r_fresh;
            slle_pkg::WA_CURSOR:    link_waddr = r_cursor;
            slle_pkg::WA_NODE:      link_waddr = r_node;
            default:                link_waddr = r_clr;
        endcase
    end

    // reset image: each free slot links to the next, last free slot and data head end in 0
    always_comb begin
        case (i_cmd.wd_sel)
            slle_pkg::WD_LINK_DATA: link_wdata = link_rdata;
            slle_pkg::WD_FRESH:     link_wdata = r_fresh;
            slle_pkg::WD_NODE:      link_wdata = r_node;
            default:                link_wdata = (r_clr < LAST_FREE) ? r_clr + 1'b1 : '0;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        r_cursor <= n_cursor;
        case (i_cmd.cur_op)
            slle_pkg::CUR_LOAD_HEAD: r_steps <= i_cmd.steps_full ? r_pos : r_pos - 1'b1;
            slle_pkg::CUR_STEP:      r_steps <= r_steps - 1'b1;
            default:                 r_steps <= r_steps;
        endcase
        if (i_cmd.cap_fresh) begin
            r_fresh <= link_rdata;
        end
        if (i_cmd.cap_node) begin
            r_node <= link_rdata;
        end
        if (i_cmd.accept) begin
            r_status <= slle_pkg::STAT_DONE;
            r_rdval  <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.cap_byte) begin
                r_rdval <= byte_rdata;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_rdval  <= r_rdval;
            r_out_len    <= slle_pkg::LEN_W'(r_count);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign pos_ext = CMPW'(r_pos);
    assign cnt_ext = CMPW'(r_count);

    assign o_stat.clr_last   = (r_clr == DATA_HEAD);
    assign o_stat.kind       = r_kind;
    assign o_stat.pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);
    assign o_stat.pos_ok_dr  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign o_stat.link_zero  = (link_rdata == '0);
    assign o_stat.steps_zero = (r_steps == '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_rdval;
    assign o_list_length = r_out_len;

    `SLLE_ASSERT_IMP(a_count_max, 1'b1, r_count <= LAST_FREE, "element count above capacity")
    `SLLE_ASSERT_IMP(a_free_head_link, i_cmd.link_we && (link_waddr == FREE_HEAD), link_wdata != DATA_HEAD, "data head linked into free list")
    `SLLE_ASSERT_IMP(a_rdval_on_error, i_cmd.out_load && (r_status != slle_pkg::STAT_DONE), r_rdval == '0, "read value on failed operation")
    `SLLE_ASSERT_NEXT(a_out_hold, r_out_valid && !i_out_ready, r_out_valid && $stable(r_out_status) && $stable(r_out_len), "result lost before taken")

endmodule

// File: hdl/slle_ctrl.sv
// ----------------------------------------------------------------------------
// slle_ctrl
// operation sequencer: clear pass, range checks, free-list and walk steps
// ----------------------------------------------------------------------------
module slle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slle_pkg::t_dp_stat  i_stat,
    output slle_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_DECODE   = 12'b0000_0000_0100,
        S_INS_FREE = 12'b0000_0000_1000,
        S_INS_POP  = 12'b0000_0001_0000,
        S_WALK     = 12'b0000_0010_0000,
        S_INS_LINK = 12'b0000_0100_0000,
        S_DEL_NEXT = 12'b0000_1000_0000,
        S_DEL_FREE = 12'b0001_0000_0000,
        S_DEL_PUSH = 12'b0010_0000_0000,
        S_RD_BYTE  = 12'b0100_0000_0000,
        S_RESP     = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.link_we  = 1'b1;
                o_cmd.wa_sel   = slle_pkg::WA_CLEAR;
                o_cmd.wd_sel   = slle_pkg::WD_CLEAR;
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    slle_pkg::KIND_INSERT: begin
                        if (!i_stat.pos_ok_ins) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = slle_pkg::STAT_RANGE;
                            n_state          = S_RESP;
                        end else begin
                            o_cmd.rd_sel = slle_pkg::RA_FREE_HEAD;
                            n_state      = S_INS_FREE;
                        end
                    end
                    slle_pkg::KIND_DELETE, slle_pkg::KIND_READ: begin
                        if (!i_stat.pos_ok_dr) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = slle_pkg::STAT_RANGE;
                            n_state          = S_RESP;
                        end else begin
                            o_cmd.cur_op     = slle_pkg::CUR_LOAD_HEAD;
                            o_cmd.steps_full = (i_stat.kind == slle_pkg::KIND_READ);
                            o_cmd.rd_sel     = slle_pkg::RA_NEXT_CURSOR;
                            n_state          = S_WALK;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_INS_FREE: begin
                o_cmd.cap_fresh = 1'b1;
                if (i_stat.link_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = slle_pkg::STAT_FULL;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.rd_sel = slle_pkg::RA_LINK_DATA;
                    n_state      = S_INS_POP;
                end
            end
            S_INS_POP: begin
                o_cmd.link_we = 1'b1;
                o_cmd.wa_sel  = slle_pkg::WA_FREE_HEAD;
                o_cmd.wd_sel  = slle_pkg::WD_LINK_DATA;
                o_cmd.byte_we = 1'b1;
                o_cmd.cur_op  = slle_pkg::CUR_LOAD_HEAD;
                o_cmd.rd_sel  = slle_pkg::RA_NEXT_CURSOR;
                n_state       = S_WALK;
            end
            S_WALK: begin
                if (!i_stat.steps_zero) begin
                    o_cmd.cur_op = slle_pkg::CUR_STEP;
                    o_cmd.rd_sel = slle_pkg::RA_NEXT_CURSOR;
                end else begin
                    case (i_stat.kind)
                        slle_pkg::KIND_INSERT: begin
                            o_cmd.link_we = 1'b1;
                            o_cmd.wa_sel  = slle_pkg::WA_FRESH;
                            o_cmd.wd_sel  = slle_pkg::WD_LINK_DATA;
                            n_state       = S_INS_LINK;
                        end
                        slle_pkg::KIND_DELETE: begin
                            o_cmd.cap_node = 1'b1;
                            o_cmd.rd_sel   = slle_pkg::RA_LINK_DATA;
                            n_state        = S_DEL_NEXT;
                        end
                        default: begin
                            n_state = S_RD_BYTE;
                        end
                    endcase
                end
            end
            S_INS_LINK: begin
                o_cmd.link_we = 1'b1;
                o_cmd.wa_sel  = slle_pkg::WA_CURSOR;
                o_cmd.wd_sel  = slle_pkg::WD_FRESH;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_RESP;
            end
            S_DEL_NEXT: begin
                o_cmd.link_we = 1'b1;
                o_cmd.wa_sel  = slle_pkg::WA_CURSOR;
                o_cmd.wd_sel  = slle_pkg::WD_LINK_DATA;
                o_cmd.rd_sel  = slle_pkg::RA_FREE_HEAD;
                n_state       = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                o_cmd.link_we = 1'b1;
                o_cmd.wa_sel  = slle_pkg::WA_NODE;
                o_cmd.wd_sel  = slle_pkg::WD_LINK_DATA;
                n_state       = S_DEL_PUSH;
            end
            S_DEL_PUSH: begin
                o_cmd.link_we = 1'b1;
                o_cmd.wa_sel  = slle_pkg::WA_FREE_HEAD;
                o_cmd.wd_sel  = slle_pkg::WD_NODE;
                o_cmd.cnt_dec = 1'b1;
                n_state       = S_RESP;
            end
            S_RD_BYTE: begin
                o_cmd.cap_byte = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: hdl/static_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// static_linked_list_engine_unit
// cursor-linked byte list in a fixed slot store with a free list
// ----------------------------------------------------------------------------
// A byte list kept as links in a SLOTS-entry store: slot 0 heads the free
// list, slot SLOTS-1 heads the data list, so up to SLOTS-2 bytes fit. One
// word in gives one word out. After reset the block first runs a clearing
// pass over all SLOTS link memory entries and takes no word until it ends.
// Words are not overlapped: the next word is taken only after the result of
// the last one is registered, or later while an earlier result still waits
// in the output register. The time a word takes is set by the list walk:
// one link memory read per step, each read address coming from the previous
// read data. Range errors return straight from the decode state, and a full
// store right after the free-list head read, both without a list walk.
// ----------------------------------------------------------------------------
module static_linked_list_engine_unit #(
    parameter int SLOTS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // operation words
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [slle_pkg::KIND_W-1:0] i_kind,
    input  logic [slle_pkg::POS_W-1:0]  i_position,
    input  logic [slle_pkg::VAL_W-1:0]  i_value,
    // result words
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [slle_pkg::STAT_W-1:0] o_status,
    output logic [slle_pkg::VAL_W-1:0]  o_read_value,
    output logic [slle_pkg::LEN_W-1:0]  o_list_length
);

    // command and status between sequencer and datapath
    slle_pkg::t_dp_cmd  dp_cmd;
    slle_pkg::t_dp_stat dp_stat;

    // sequencer: clear pass, checks, free-list pops/pushes and walk control
    slle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // datapath: link and byte memories, cursor, count and result register
    slle_datapath #(.SLOTS(SLOTS)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_list_length (o_list_length)
    );

endmodule

// File: tb/static_linked_list_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// static_linked_list_engine_unit_tb
// self-checking bench for the cursor-linked byte list engine
// ----------------------------------------------------------------------------
// Operation words go in one at a time over a valid/ready channel. At each
// accepted word a shadow copy of the link store, the byte store and the
// element count is updated, and the result word it must produce is queued.
// A receiving process pops the queue on each accepted result word and
// compares status, read byte and length field by field. The stimulus runs
// corner cases on a short list, fills the store to capacity, holds results
// back, pauses the sender and then runs a long random mix that moves the
// list length between near empty and full.
// ----------------------------------------------------------------------------
module static_linked_list_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = 128;
    localparam int CAPACITY       = SLOTS - 2;
    localparam int FREE_HEAD      = 0;
    localparam int DATA_HEAD      = SLOTS - 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_OPS     = 900;

    // kind code the block must ignore
    localparam logic [slle_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [slle_pkg::STAT_W-1:0] status;
        logic [slle_pkg::VAL_W-1:0]  read_value;
        logic [slle_pkg::LEN_W-1:0]  list_length;
    } t_list_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [slle_pkg::KIND_W-1:0]   i_kind;
    logic [slle_pkg::POS_W-1:0]    i_position;
    logic [slle_pkg::VAL_W-1:0]    i_value;
    logic                          o_valid;
    logic                          i_ready;
    logic [slle_pkg::STAT_W-1:0]   o_status;
    logic [slle_pkg::VAL_W-1:0]    o_read_value;
    logic [slle_pkg::LEN_W-1:0]    o_list_length;

    // shadow of the block state
    logic [slle_pkg::POS_W-1:0]    shadow_link [SLOTS];
    logic [slle_pkg::VAL_W-1:0]    shadow_byte [SLOTS];
    logic [slle_pkg::LEN_W-1:0]    shadow_count;

    // result words still to come, oldest first
    t_list_result                  awaited_results [$];

    int                 mismatch_count = 0;
    bit                 steady = 1'b0;    // no idling on either side
    bit                 hold_req = 1'b0;  // ask receiver for a long hold-off
    int                 hold_left = 0;

    static_linked_list_engine_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_kind(i_kind),
        .i_position(i_position),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_read_value(o_read_value),
        .o_list_length(o_list_length)
    );

    always #5 i_clk = ~i_clk;

    // follow the data list from its head slot
    function automatic logic [slle_pkg::POS_W-1:0] walk_from_head(int steps);
        logic [slle_pkg::POS_W-1:0] slot;
        slot = slle_pkg::POS_W'(DATA_HEAD);
        for (int j = 0; j < steps; j++) slot = shadow_link[slot];
        return slot;
    endfunction

    // apply one operation to the shadow state, return the word it yields
    function automatic t_list_result apply_list_op(logic [slle_pkg::KIND_W-1:0] kind,
                                                   logic [slle_pkg::POS_W-1:0] pos,
                                                   logic [slle_pkg::VAL_W-1:0] val);
        t_list_result               res;
        logic [slle_pkg::POS_W-1:0] fresh;
        logic [slle_pkg::POS_W-1:0] pred;
        logic [slle_pkg::POS_W-1:0] node;
        res = '0;
        case (kind)
            slle_pkg::KIND_INSERT: begin
                // position is checked before the free slot
                if (pos == 0 || int'(pos) > int'(shadow_count) + 1) begin
                    res.status = slle_pkg::STAT_RANGE;
                end else if (shadow_link[FREE_HEAD] == slle_pkg::POS_W'(FREE_HEAD)) begin
                    res.status = slle_pkg::STAT_FULL;
                end else begin
                    fresh = shadow_link[FREE_HEAD];
                    shadow_link[FREE_HEAD] = shadow_link[fresh];
                    shadow_byte[fresh] = val;
                    pred = walk_from_head(int'(pos) - 1);
                    shadow_link[fresh] = shadow_link[pred];
                    shadow_link[pred] = fresh;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            slle_pkg::KIND_DELETE: begin
                if (pos == 0 || int'(pos) > int'(shadow_count)) begin
                    res.status = slle_pkg::STAT_RANGE;
                end else begin
                    pred = walk_from_head(int'(pos) - 1);
                    node = shadow_link[pred];
                    shadow_link[pred] = shadow_link[node];
                    // freed slot goes to the front of the free list
                    shadow_link[node] = shadow_link[FREE_HEAD];
                    shadow_link[FREE_HEAD] = node;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            slle_pkg::KIND_READ: begin
                if (pos == 0 || int'(pos) > int'(shadow_count)) begin
                    res.status = slle_pkg::STAT_RANGE;
                end else begin
                    res.read_value = shadow_byte[walk_from_head(int'(pos))];
                end
            end
            default: begin
                // unused kind changes nothing
            end
        endcase
        res.list_length = shadow_count;
        return res;
    endfunction

    // a position holding an element, or 1 on an empty list
    function automatic logic [slle_pkg::POS_W-1:0] pick_held_pos();
        if (shadow_count == 0) return slle_pkg::POS_W'(1);
        return slle_pkg::POS_W'($urandom_range(1, shadow_count));
    endfunction

    // a position where an insert is legal
    function automatic logic [slle_pkg::POS_W-1:0] pick_insert_pos();
        return slle_pkg::POS_W'($urandom_range(1, int'(shadow_count) + 1));
    endfunction

    // offer one operation word and wait until it is taken
    // called in the active region just after a rising edge
    task automatic offer_op(logic [slle_pkg::KIND_W-1:0] kind,
                            logic [slle_pkg::POS_W-1:0] pos,
                            logic [slle_pkg::VAL_W-1:0] val);
        while (!steady && $urandom_range(0, 99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (!o_ready);
        awaited_results.push_back(apply_list_op(kind, pos, val));
    endtask

    // compare one result word with the oldest expectation
    task automatic check_result_word();
        t_list_result want;
        if (awaited_results.size() == 0) begin
            $error("result word with nothing expected: status %0d value %0d length %0d",
                   o_status, o_read_value, o_list_length);
            mismatch_count++;
        end else begin
            want = awaited_results.pop_front();
            if (o_status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, o_status);
                mismatch_count++;
            end
            if (o_read_value !== want.read_value) begin
                $error("read_value: expected %0d, actual %0d",
                       want.read_value, o_read_value);
                mismatch_count++;
            end
            if (o_list_length !== want.list_length) begin
                $error("list_length: expected %0d, actual %0d",
                       want.list_length, o_list_length);
                mismatch_count++;
            end
        end
    endtask

    // receiving side: check, then choose ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_result_word();
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            // long hold-off, counted here
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= 14);
        end
    end

    // ends the run when nothing moves on either channel for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // extremes and range errors on a short list
    task automatic test_short_list_corners();
        offer_op(slle_pkg::KIND_READ,   7'd1,   8'h00);   // read on empty list
        offer_op(slle_pkg::KIND_DELETE, 7'd1,   8'h00);   // delete on empty list
        offer_op(slle_pkg::KIND_INSERT, 7'd0,   8'h11);   // position zero
        offer_op(slle_pkg::KIND_INSERT, 7'd2,   8'h22);   // past the end
        offer_op(slle_pkg::KIND_INSERT, 7'd1,   8'h00);
        offer_op(slle_pkg::KIND_INSERT, 7'd2,   8'hFF);   // append
        offer_op(slle_pkg::KIND_INSERT, 7'd1,   8'hA5);   // at the front
        offer_op(slle_pkg::KIND_INSERT, 7'd2,   8'h5A);   // in the middle
        offer_op(slle_pkg::KIND_READ,   7'd1,   8'hFF);
        offer_op(slle_pkg::KIND_READ,   7'd2,   8'h00);
        offer_op(slle_pkg::KIND_READ,   7'd3,   8'h00);
        offer_op(slle_pkg::KIND_READ,   7'd4,   8'h00);
        offer_op(slle_pkg::KIND_READ,   7'd0,   8'h00);
        offer_op(slle_pkg::KIND_READ,   7'd5,   8'h00);   // one past the end
        offer_op(slle_pkg::KIND_READ,   7'd127, 8'h00);
        offer_op(KIND_UNUSED,           7'd127, 8'hFF);   // ignored kind
        offer_op(KIND_UNUSED,           7'd0,   8'h00);
        offer_op(slle_pkg::KIND_DELETE, 7'd0,   8'h00);
        offer_op(slle_pkg::KIND_DELETE, 7'd127, 8'h00);
        offer_op(slle_pkg::KIND_DELETE, 7'd2,   8'h00);   // middle
        offer_op(slle_pkg::KIND_DELETE, 7'd3,   8'h00);   // last
        offer_op(slle_pkg::KIND_DELETE, 7'd1,   8'h00);   // first
        offer_op(slle_pkg::KIND_READ,   7'd1,   8'h00);
        offer_op(slle_pkg::KIND_DELETE, 7'd1,   8'h00);   // back to empty
    endtask

    // fill to capacity, then hit the full store
    task automatic test_fill_to_capacity();
        while (shadow_count < CAPACITY)
            offer_op(slle_pkg::KIND_INSERT, pick_insert_pos(),
                     slle_pkg::VAL_W'($urandom));
        offer_op(slle_pkg::KIND_INSERT, 7'd127, 8'hFF);   // legal position, no free slot
        offer_op(slle_pkg::KIND_INSERT, 7'd1,   8'h00);
        offer_op(slle_pkg::KIND_INSERT, 7'd0,   8'h33);   // range wins over full
        offer_op(slle_pkg::KIND_READ,   7'd126, 8'h00);
        offer_op(slle_pkg::KIND_READ,   7'd127, 8'h00);
        offer_op(slle_pkg::KIND_DELETE, 7'd127, 8'h00);
        offer_op(slle_pkg::KIND_DELETE, 7'd126, 8'h00);
        offer_op(slle_pkg::KIND_INSERT, 7'd126, 8'hC3);   // reuse the freed slot
        offer_op(slle_pkg::KIND_DELETE, 7'd1,   8'h00);
        offer_op(slle_pkg::KIND_INSERT, 7'd64,  8'h81);
    endtask

    // results held back so the block fills up and stalls its input
    task automatic test_result_hold_off();
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            offer_op(slle_pkg::KIND_READ, pick_held_pos(), slle_pkg::VAL_W'($urandom));
    endtask

    // sender waits until every result has come
    task automatic test_sender_pause();
        for (int i = 0; i < 8; i++)
            offer_op(slle_pkg::KIND_DELETE, pick_held_pos(), slle_pkg::VAL_W'($urandom));
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        for (int i = 0; i < 8; i++)
            offer_op(slle_pkg::KIND_INSERT, pick_insert_pos(), slle_pkg::VAL_W'($urandom));
    endtask

    // mostly legal operations, length drifting toward a moving goal
    task automatic test_random_mix(int n_ops);
        int                          goal;
        int                          r;
        logic [slle_pkg::KIND_W-1:0] kind;
        logic [slle_pkg::POS_W-1:0]  pos;
        goal = 10;
        for (int i = 0; i < n_ops; i++) begin
            if (i % 120 == 0)
                goal = ($urandom_range(0, 3) == 0) ? CAPACITY : $urandom_range(0, 40);
            // one long stretch without idling
            steady = (i >= n_ops / 3) && (i < n_ops / 3 + 150);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                // noise: any kind, any position
                kind = slle_pkg::KIND_W'($urandom_range(0, 3));
                pos  = slle_pkg::POS_W'($urandom_range(0, 127));
            end else if (r < 35) begin
                kind = slle_pkg::KIND_READ;
                pos  = pick_held_pos();
            end else if (int'(shadow_count) < goal ? r < 80 : r < 45) begin
                kind = slle_pkg::KIND_INSERT;
                pos  = pick_insert_pos();
            end else begin
                kind = slle_pkg::KIND_DELETE;
                pos  = pick_held_pos();
            end
            offer_op(kind, pos, slle_pkg::VAL_W'($urandom));
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_kind     = slle_pkg::KIND_INSERT;
        i_position = '0;
        i_value    = '0;
        // shadow state after reset: free list 1..SLOTS-2, data list empty
        for (int i = 0; i < SLOTS; i++) begin
            shadow_link[i] = slle_pkg::POS_W'(i + 1);
            shadow_byte[i] = '0;
        end
        shadow_link[SLOTS-2] = slle_pkg::POS_W'(FREE_HEAD);
        shadow_link[SLOTS-1] = slle_pkg::POS_W'(FREE_HEAD);
        shadow_count = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_list_corners();
        test_fill_to_capacity();
        test_result_hold_off();
        test_sender_pause();
        test_random_mix(RANDOM_OPS);

        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: static_linked_list_engine_unit.f
+incdir+hdl
hdl/slle_pkg.sv
hdl/slle_ram.sv
hdl/slle_datapath.sv
hdl/slle_ctrl.sv
hdl/static_linked_list_engine_unit.sv
tb/static_linked_list_engine_unit_tb.sv
